// ===== rtl/hia_pkg.sv =====
// Package for the handle index allocator.
// Holds the word types, opcode and status codes, and the stack command types.
// No dependencies.
package hia_pkg;

    localparam int IDX_W = 12;
    localparam int REF_W = 32;

    localparam logic [1:0] OP_ACQUIRE   = 2'd0;
    localparam logic [1:0] OP_RELEASE   = 2'd1;
    localparam logic [1:0] OP_WRITE_REF = 2'd2;
    localparam logic [1:0] OP_READ_REF  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_REL_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] slot_index;
        logic [REF_W-1:0] object_ref;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [REF_W-1:0] read_ref;
        logic [1:0]       status;
    } t_out_word;

    typedef struct packed {
        logic             acquire;
        logic             release_idx;
        logic [IDX_W-1:0] idx;
    } t_stk_cmd;

    typedef struct packed {
        logic no_free;
        logic rel_full;
    } t_stk_stat;

    typedef enum logic {
        PH_INIT,
        PH_RUN
    } t_phase;

endpackage

// ===== rtl/hia_stack.sv =====
// Free and release stacks of the handle index allocator, both banks in one memory.
// Holds the stack counts and the bank swap; fills bank a during the init pass.
// Depends on hia_pkg.
module hia_stack #(
    parameter int CAPACITY = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_init_we,
    input  logic [$clog2(CAPACITY)-1:0] i_init_addr,
    input  hia_pkg::t_stk_cmd         i_cmd,
    output hia_pkg::t_stk_stat        o_stat,
    output logic [hia_pkg::IDX_W-1:0] o_pop_data
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = 2 ** (AW + 1);

    logic [hia_pkg::IDX_W-1:0] r_mem [DEPTH];
    logic [hia_pkg::IDX_W-1:0] r_pop_data;
    logic [CW-1:0]             r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic                      r_free_is_b, n_free_is_b;

    logic [CW-1:0]             free_cnt, rel_cnt, pop_ptr;
    logic                      no_free, rel_full, do_pop, do_push;
    logic                      we;
    logic [AW:0]               waddr;
    logic [hia_pkg::IDX_W-1:0] wdata;
    logic [31:0]               init_val;

    assign free_cnt = r_free_is_b ? r_cnt_b : r_cnt_a;
    assign rel_cnt  = r_free_is_b ? r_cnt_a : r_cnt_b;
    assign pop_ptr  = free_cnt - CW'(1);
    assign no_free  = (free_cnt == '0);
    assign rel_full = (32'(rel_cnt) >= 32'(CAPACITY));
    assign do_pop   = i_cmd.acquire && !no_free;
    assign do_push  = i_cmd.release_idx && !rel_full;
    assign init_val = 32'(CAPACITY - 1) - 32'(i_init_addr);

    assign o_stat.no_free  = no_free;
    assign o_stat.rel_full = rel_full;
    assign o_pop_data      = r_pop_data;

    always_comb begin
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_free_is_b = r_free_is_b;
        if (do_pop) begin
            if (r_free_is_b) begin
                n_cnt_b = pop_ptr;
            end else begin
                n_cnt_a = pop_ptr;
            end
        end
        if (do_push) begin
            if (r_free_is_b) begin
                n_cnt_a = rel_cnt + CW'(1);
            end else begin
                n_cnt_b = rel_cnt + CW'(1);
            end
        end
        if (i_cmd.release_idx && no_free) begin
            n_free_is_b = !r_free_is_b;
        end
    end

    always_comb begin
        we    = i_init_we || do_push;
        waddr = i_init_we ? {1'b0, i_init_addr} : {!r_free_is_b, rel_cnt[AW-1:0]};
        wdata = i_init_we ? init_val[hia_pkg::IDX_W-1:0] : i_cmd.idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= CW'(CAPACITY - 1);
            r_cnt_b     <= '0;
            r_free_is_b <= 1'b0;
        end else begin
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_free_is_b <= n_free_is_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (do_pop) begin
            r_pop_data <= r_mem[{r_free_is_b, pop_ptr[AW-1:0]}];
        end
    end

endmodule

// ===== rtl/handle_index_allocator.sv =====
// Handle index allocator: an accepted word passes the stage-1 and output registers;
// one word per cycle while i_out_ready is high; stack and table reads are registered.
// Stage 1 can take one more word while a result waits in the output register.
// Reset (synchronous) starts an init pass that fills bank a of the
// stack memory and clears the handle table; no word is accepted until it ends.
// Depends on hia_pkg and hia_stack.
module handle_index_allocator #(
    parameter int CAPACITY  = 4096,
    parameter int REF_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hia_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hia_pkg::t_out_word o_out_word
);

    localparam int AW = $clog2(CAPACITY);

    hia_pkg::t_phase   r_phase, n_phase;
    logic [AW-1:0]     r_init_addr, n_init_addr;
    logic              init_we;

    logic [REF_WIDTH-1:0] r_tbl [CAPACITY];
    logic [REF_WIDTH-1:0] r_tbl_rd;

    logic               r_s1_valid;
    logic [1:0]         r_s1_op;
    logic [1:0]         r_s1_status;
    logic               r_s1_in_range;
    logic               r_out_valid;
    hia_pkg::t_out_word r_out_word, n_out_word;

    hia_pkg::t_stk_cmd  stk_cmd;
    hia_pkg::t_stk_stat stk_stat;
    logic [hia_pkg::IDX_W-1:0] pop_data;

    logic        accept, out_free, s1_adv, in_range;
    logic [AW-1:0] slot_addr;
    logic [31:0] slot_ext;
    logic [63:0] wr_ext, rd_ext;
    logic [1:0]  status;
    logic        tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [REF_WIDTH-1:0] tbl_wdata;

    always_comb begin
        n_phase     = r_phase;
        n_init_addr = r_init_addr;
        init_we     = 1'b0;
        case (r_phase)
            hia_pkg::PH_INIT: begin
                init_we     = 1'b1;
                n_init_addr = r_init_addr + AW'(1);
                if (32'(r_init_addr) == 32'(CAPACITY - 1)) begin
                    n_phase = hia_pkg::PH_RUN;
                end
            end
            hia_pkg::PH_RUN: begin
                n_phase = hia_pkg::PH_RUN;
            end
            default: begin
                n_phase = hia_pkg::PH_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hia_pkg::PH_INIT;
            r_init_addr <= '0;
        end else begin
            r_phase     <= n_phase;
            r_init_addr <= n_init_addr;
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = (r_phase == hia_pkg::PH_RUN) && (!r_s1_valid || out_free);
    assign accept     = i_in_valid && o_in_ready;

    assign slot_ext  = 32'(i_in_word.slot_index);
    assign slot_addr = slot_ext[AW-1:0];
    assign in_range  = slot_ext < 32'(CAPACITY);
    assign wr_ext    = 64'(i_in_word.object_ref);

    assign stk_cmd.acquire     = accept && (i_in_word.opcode == hia_pkg::OP_ACQUIRE);
    assign stk_cmd.release_idx = accept && (i_in_word.opcode == hia_pkg::OP_RELEASE);
    assign stk_cmd.idx         = i_in_word.slot_index;

    hia_stack #(
        .CAPACITY (CAPACITY)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init_we   (init_we),
        .i_init_addr (r_init_addr),
        .i_cmd       (stk_cmd),
        .o_stat      (stk_stat),
        .o_pop_data  (pop_data)
    );

    always_comb begin
        status = hia_pkg::ST_OK;
        if (i_in_word.opcode == hia_pkg::OP_ACQUIRE && stk_stat.no_free) begin
            status = hia_pkg::ST_NO_FREE;
        end else if (i_in_word.opcode == hia_pkg::OP_RELEASE && stk_stat.rel_full) begin
            status = hia_pkg::ST_REL_FULL;
        end
    end

    always_comb begin
        tbl_we    = init_we ||
                    (accept && i_in_word.opcode == hia_pkg::OP_WRITE_REF && in_range);
        tbl_waddr = init_we ? r_init_addr : slot_addr;
        tbl_wdata = init_we ? '0 : wr_ext[REF_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        if (accept && i_in_word.opcode == hia_pkg::OP_READ_REF && in_range) begin
            r_tbl_rd <= r_tbl[slot_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op       <= i_in_word.opcode;
            r_s1_status   <= status;
            r_s1_in_range <= in_range;
        end
    end

    assign rd_ext = 64'(r_tbl_rd);

    always_comb begin
        n_out_word.granted_index = '0;
        n_out_word.read_ref      = '0;
        n_out_word.status        = r_s1_status;
        if (r_s1_op == hia_pkg::OP_ACQUIRE && r_s1_status == hia_pkg::ST_OK) begin
            n_out_word.granted_index = pop_data;
        end
        if (r_s1_op == hia_pkg::OP_READ_REF && r_s1_in_range) begin
            n_out_word.read_ref = rd_ext[hia_pkg::REF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== tb/tb_handle_index_allocator.sv =====
// Testbench for handle_index_allocator: directed, bulk and random words checked
// against an in-bench model of the free and release stacks and the handle table.
// Depends on hia_pkg and the handle_index_allocator RTL.
`timescale 1ns / 100ps

module tb_handle_index_allocator;

    localparam int CAPACITY  = 4096;
    localparam int IDX_W     = hia_pkg::IDX_W;
    localparam int REF_W     = hia_pkg::REF_W;
    localparam int MAX_CYC   = 1_000_000;
    localparam int HOLD_LEN  = 400;
    localparam int TAIL_CYC  = 8;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    hia_pkg::t_in_word  i_in_word  = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    hia_pkg::t_out_word o_out_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int cycle_cnt     = 0;
    int err_cnt       = 0;

    // allocator state mirror
    logic [IDX_W-1:0] stk_mem [2][CAPACITY];
    int               stk_cnt [2];
    int               free_bank;
    logic [REF_W-1:0] ref_tab [CAPACITY];

    hia_pkg::t_out_word pending_results [$];
    logic [IDX_W-1:0]   live_handles [$];

    handle_index_allocator #(
        .CAPACITY  (CAPACITY),
        .REF_WIDTH (REF_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYC) begin
            $display("FAIL handle_index_allocator");
            $finish;
        end
    end

    task automatic clear_model();
        for (int k = 0; k < CAPACITY; k++) begin
            stk_mem[0][k] = (k < CAPACITY - 1) ? IDX_W'(CAPACITY - 1 - k) : '0;
            stk_mem[1][k] = '0;
            ref_tab[k]    = '0;
        end
        stk_cnt[0] = CAPACITY - 1;
        stk_cnt[1] = 0;
        free_bank  = 0;
    endtask

    function automatic hia_pkg::t_out_word allocator_step(hia_pkg::t_in_word w);
        hia_pkg::t_out_word res;
        int                 rel_bank;
        res      = '0;
        rel_bank = 1 - free_bank;
        case (w.opcode)
            hia_pkg::OP_ACQUIRE: begin
                if (stk_cnt[free_bank] == 0) begin
                    res.status = hia_pkg::ST_NO_FREE;
                end else begin
                    stk_cnt[free_bank]--;
                    res.granted_index = stk_mem[free_bank][stk_cnt[free_bank]];
                end
            end
            hia_pkg::OP_RELEASE: begin
                if (stk_cnt[rel_bank] >= CAPACITY) begin
                    res.status = hia_pkg::ST_REL_FULL;
                end else begin
                    stk_mem[rel_bank][stk_cnt[rel_bank]] = w.slot_index;
                    stk_cnt[rel_bank]++;
                end
                if (stk_cnt[free_bank] == 0)
                    free_bank = rel_bank;
            end
            hia_pkg::OP_WRITE_REF: begin
                if (int'(w.slot_index) < CAPACITY)
                    ref_tab[w.slot_index] = w.object_ref;
            end
            default: begin
                if (int'(w.slot_index) < CAPACITY)
                    res.read_ref = ref_tab[w.slot_index];
            end
        endcase
        return res;
    endfunction

    // one word through the input handshake; expectation logged at accept
    task automatic put_word(input logic [1:0] op, input logic [IDX_W-1:0] slot,
                            input logic [REF_W-1:0] obj,
                            output hia_pkg::t_out_word exp);
        hia_pkg::t_in_word w;
        w.opcode     = op;
        w.slot_index = slot;
        w.object_ref = obj;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        exp = allocator_step(w);
        pending_results = {pending_results, exp};
    endtask

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void check_field(string name, logic [REF_W-1:0] exp,
                                        logic [REF_W-1:0] act);
        if (act !== exp) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        hia_pkg::t_out_word exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %0h", o_out_word);
                err_cnt++;
            end else begin
                exp = pending_results.pop_front();
                check_field("granted_index", REF_W'(exp.granted_index),
                            REF_W'(o_out_word.granted_index));
                check_field("read_ref", exp.read_ref, o_out_word.read_ref);
                check_field("status", REF_W'(exp.status), REF_W'(o_out_word.status));
            end
        end
    end

    task automatic test_directed();
        hia_pkg::t_out_word r;
        put_word(hia_pkg::OP_READ_REF, 12'd0, 32'h0, r);
        put_word(hia_pkg::OP_READ_REF, 12'hFFF, 32'hFFFF_FFFF, r);
        put_word(hia_pkg::OP_ACQUIRE, 12'd0, 32'h0, r);
        put_word(hia_pkg::OP_ACQUIRE, 12'hFFF, 32'hFFFF_FFFF, r);
        put_word(hia_pkg::OP_ACQUIRE, 12'h555, 32'h5555_5555, r);
        put_word(hia_pkg::OP_WRITE_REF, 12'd1, 32'hFFFF_FFFF, r);
        put_word(hia_pkg::OP_WRITE_REF, 12'hFFF, 32'h0, r);
        put_word(hia_pkg::OP_WRITE_REF, 12'hFFF, 32'hAAAA_AAAA, r);
        put_word(hia_pkg::OP_WRITE_REF, 12'd0, 32'h5A5A_A5A5, r);
        put_word(hia_pkg::OP_WRITE_REF, 12'd2, 32'h0000_0001, r);
        put_word(hia_pkg::OP_READ_REF, 12'd1, 32'h0, r);
        put_word(hia_pkg::OP_READ_REF, 12'hFFF, 32'h0, r);
        put_word(hia_pkg::OP_READ_REF, 12'd0, 32'h0, r);
        put_word(hia_pkg::OP_READ_REF, 12'd2, 32'h0, r);
        put_word(hia_pkg::OP_READ_REF, 12'd3, 32'h0, r);
        // reserved and already free indices go back as given
        put_word(hia_pkg::OP_RELEASE, 12'd2, 32'hFFFF_FFFF, r);
        put_word(hia_pkg::OP_RELEASE, 12'd0, 32'h0, r);
        put_word(hia_pkg::OP_RELEASE, 12'hFFF, 32'h0, r);
        put_word(hia_pkg::OP_RELEASE, 12'd2, 32'h0, r);
        put_word(hia_pkg::OP_ACQUIRE, 12'd0, 32'h0, r);
        put_word(hia_pkg::OP_WRITE_REF, 12'd1, 32'h0, r);
        put_word(hia_pkg::OP_READ_REF, 12'd1, 32'h0, r);
    endtask

    task automatic test_random(input int n_words);
        hia_pkg::t_out_word r;
        int                 sel;
        int                 pos;
        logic [1:0]         op;
        logic [IDX_W-1:0]   slot;
        for (int i = 0; i < n_words; i++) begin
            sel = $urandom_range(99);
            op  = (sel < 30) ? hia_pkg::OP_ACQUIRE : (sel < 55) ? hia_pkg::OP_RELEASE :
                  (sel < 80) ? hia_pkg::OP_WRITE_REF : hia_pkg::OP_READ_REF;
            pos = -1;
            if (live_handles.size() > 0 && $urandom_range(3) != 0) begin
                pos  = $urandom_range(live_handles.size() - 1);
                slot = live_handles[pos];
            end else begin
                slot = 12'($urandom_range(4095));
            end
            if (op == hia_pkg::OP_RELEASE && pos >= 0)
                live_handles.delete(pos);
            put_word(op, slot, $urandom, r);
            if (op == hia_pkg::OP_ACQUIRE && r.status == hia_pkg::ST_OK &&
                r.granted_index != 0)
                live_handles = {live_handles, r.granted_index};
        end
    endtask

    task automatic test_back_pressure();
        hold_request = HOLD_LEN;
        test_random(80);
    endtask

    task automatic finish_run();
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS handle_index_allocator");
        else
            $display("FAIL handle_index_allocator");
        $finish;
    endtask

    initial begin
        clear_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 64;
        test_directed();
        test_random(500);

        send_idle_pct = 64;
        recv_idle_pct = 27;
        test_random(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_pressure();
        test_random(400);

        finish_run();
    end

endmodule

// ===== files.f =====
rtl/hia_pkg.sv
rtl/hia_stack.sv
rtl/handle_index_allocator.sv
tb/tb_handle_index_allocator.sv
